[rtl/lfucl_pkg.sv]
package lfucl_pkg;

   localparam int ENTRIES_DEFAULT    = 16;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int KEY_BITS           = 32;
   localparam int VALUE_BITS         = 32;
   localparam int CAP_BITS           = 5;

   localparam logic [CAP_BITS-1:0]   CAP_RESET  = 5'd16;
   localparam logic                  FUNC_GET   = 1'b0;
   localparam logic                  FUNC_PUT   = 1'b1;
   localparam logic [VALUE_BITS-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic valid;
      logic is_slot;
      logic have;
      logic age_all;
   } cmp_ctrl_type;

   typedef struct packed {
      logic key_match;
      logic victim_better;
      logic rank_age;
   } cmp_result_type;

endpackage

[rtl/lfucl_ram.sv]
module lfucl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lfucl_entry_cmp.sv]
module lfucl_entry_cmp #(
   parameter int COUNT_BITS = lfucl_pkg::COUNT_BITS_DEFAULT,
   parameter int RANK_BITS  = 4
) (
   input  lfucl_pkg::cmp_ctrl_type          ctrl,
   input  logic [lfucl_pkg::KEY_BITS-1:0]   entry_key,
   input  logic [lfucl_pkg::KEY_BITS-1:0]   lookup_key,
   input  logic [COUNT_BITS-1:0]            entry_count,
   input  logic [RANK_BITS-1:0]             entry_rank,
   input  logic [COUNT_BITS-1:0]            best_count,
   input  logic [RANK_BITS-1:0]             best_rank,
   input  logic [RANK_BITS-1:0]             old_rank,
   output lfucl_pkg::cmp_result_type        result
);

   logic count_less;
   logic count_equal;
   logic rank_older;
   logic rank_newer;

   assign count_less  = entry_count < best_count;
   assign count_equal = entry_count == best_count;
   assign rank_older  = entry_rank > best_rank;
   assign rank_newer  = entry_rank < old_rank;

   always_comb begin
      result.key_match     = ctrl.valid && (entry_key == lookup_key);
      result.victim_better = ctrl.valid &&
                             (!ctrl.have || count_less || (count_equal && rank_older));
      result.rank_age      = ctrl.valid && !ctrl.is_slot && (ctrl.age_all || rank_newer);
   end

endmodule

[rtl/lfu_cache_lookup_replace_unit.sv]
// LFU key-value cache with LRU tie-break, ENTRIES entries. A get on a hit returns the stored
// value and bumps the entry's use count (saturating at COUNT_BITS ones); a miss returns -1.
// A put updates a present key, or inserts a new one with count one, evicting the valid entry
// of lowest count (oldest among equal counts) when fill reaches csr capacity (values above
// ENTRIES act as ENTRIES, zero makes puts no-ops). One word is worked on at a time: it holds
// the block through one pass through the key/value/count RAM read port that matches the key
// and picks the victim and, when an entry changes, a second pass through the rank RAM that
// ages recency ranks, both one entry per cycle through a single shared compare unit. The result
// sits in an output register, so the next word is taken while it waits. Valid bits clear at
// reset; no clearing pass is needed.
module lfu_cache_lookup_replace_unit #(
   parameter int ENTRIES    = lfucl_pkg::ENTRIES_DEFAULT,
   parameter int COUNT_BITS = lfucl_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [lfucl_pkg::CAP_BITS-1:0]        csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_func,
   input  logic signed [lfucl_pkg::KEY_BITS-1:0] req_lookup_key,
   input  logic signed [lfucl_pkg::VALUE_BITS-1:0] req_put_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_hit,
   output logic signed [lfucl_pkg::VALUE_BITS-1:0] rsp_read_value,
   output logic                                  rsp_evicted
);

   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_BITS = IDX_BITS;
   localparam int FILL_BITS = $clog2(ENTRIES + 1);
   localparam int CMP_BITS  = (FILL_BITS > lfucl_pkg::CAP_BITS) ? FILL_BITS
                                                                : lfucl_pkg::CAP_BITS;
   localparam int KB        = lfucl_pkg::KEY_BITS;
   localparam int VB        = lfucl_pkg::VALUE_BITS;

   localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(ENTRIES - 1);
   localparam logic [FILL_BITS-1:0]  FILL_MAX  = FILL_BITS'(ENTRIES);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_RANK   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [lfucl_pkg::CAP_BITS-1:0] cap_ff, cap_in;
   logic                           func_ff, func_in;
   logic [KB-1:0]                  key_ff, key_in;
   logic [VB-1:0]                  value_ff, value_in;
   logic [FILL_BITS-1:0]           ctr_ff, ctr_in;
   logic                           rd_pend_ff, rd_pend_in;
   logic [IDX_BITS-1:0]            rd_idx_ff, rd_idx_in;
   logic [ENTRIES-1:0]             valid_ff, valid_in;
   logic [FILL_BITS-1:0]           fill_ff, fill_in;

   logic                           found_ff, found_in;
   logic [IDX_BITS-1:0]            slot_ff, slot_in;
   logic [RANK_BITS-1:0]           old_rank_ff, old_rank_in;
   logic [COUNT_BITS-1:0]          hit_count_ff, hit_count_in;
   logic [VB-1:0]                  hit_value_ff, hit_value_in;
   logic                           have_ff, have_in;
   logic [IDX_BITS-1:0]            best_slot_ff, best_slot_in;
   logic [COUNT_BITS-1:0]          best_count_ff, best_count_in;
   logic [RANK_BITS-1:0]           best_rank_ff, best_rank_in;
   logic                           free_found_ff, free_found_in;
   logic [IDX_BITS-1:0]            free_slot_ff, free_slot_in;

   logic [IDX_BITS-1:0]            upd_slot_ff, upd_slot_in;
   logic [RANK_BITS-1:0]           upd_old_ff, upd_old_in;
   logic                           age_all_ff, age_all_in;
   logic                           res_hit_ff, res_hit_in;
   logic [VB-1:0]                  res_value_ff, res_value_in;
   logic                           res_evict_ff, res_evict_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff, rsp_hit_in;
   logic [VB-1:0]                  rsp_value_ff, rsp_value_in;
   logic                           rsp_evicted_ff, rsp_evicted_in;

   logic [KB-1:0]                  ram_key;
   logic [VB-1:0]                  ram_value;
   logic [COUNT_BITS-1:0]          ram_count;
   logic [RANK_BITS-1:0]           ram_rank;
   logic [IDX_BITS-1:0]            rd_addr;

   logic                           dec_key_we, dec_value_we, dec_count_we;
   logic [COUNT_BITS-1:0]          dec_count;
   logic [IDX_BITS-1:0]            dec_slot;
   logic                           dec_rank, dec_insert;
   logic                           rank_we;
   logic [RANK_BITS-1:0]           rank_wdata;

   logic [CMP_BITS-1:0]            cap_eff;
   logic                           cap_zero, cache_full, insert_free, insert_evict;
   logic                           pass_last;

   lfucl_pkg::cmp_ctrl_type        cmp_ctrl;
   lfucl_pkg::cmp_result_type      cmp_res;

   assign rd_addr   = ctr_ff[IDX_BITS-1:0];
   assign pass_last = rd_pend_ff && (rd_idx_ff == LAST_IDX);

   assign cap_eff    = (CMP_BITS'(cap_ff) > CMP_BITS'(ENTRIES)) ? CMP_BITS'(ENTRIES)
                                                                  : CMP_BITS'(cap_ff);
   assign cap_zero   = cap_ff == '0;
   assign cache_full = CMP_BITS'(fill_ff) >= cap_eff;
   assign insert_free  = (func_ff == lfucl_pkg::FUNC_PUT) && !found_ff && !cap_zero &&
                         !cache_full;
   assign insert_evict = (func_ff == lfucl_pkg::FUNC_PUT) && !found_ff && !cap_zero &&
                         cache_full && have_ff;

   lfucl_ram #(.WIDTH(KB), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (dec_key_we),
      .wr_addr (dec_slot),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_key)
   );

   lfucl_ram #(.WIDTH(VB), .DEPTH(ENTRIES)) u_value_ram (
      .clock   (clock),
      .wr_en   (dec_value_we),
      .wr_addr (dec_slot),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_value)
   );

   lfucl_ram #(.WIDTH(COUNT_BITS), .DEPTH(ENTRIES)) u_count_ram (
      .clock   (clock),
      .wr_en   (dec_count_we),
      .wr_addr (dec_slot),
      .wr_data (dec_count),
      .rd_addr (rd_addr),
      .rd_data (ram_count)
   );

   lfucl_ram #(.WIDTH(RANK_BITS), .DEPTH(ENTRIES)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (rd_idx_ff),
      .wr_data (rank_wdata),
      .rd_addr (rd_addr),
      .rd_data (ram_rank)
   );

   always_comb begin
      cmp_ctrl.valid   = valid_ff[rd_idx_ff];
      cmp_ctrl.is_slot = rd_idx_ff == upd_slot_ff;
      cmp_ctrl.have    = have_ff;
      cmp_ctrl.age_all = age_all_ff;
   end

   lfucl_entry_cmp #(.COUNT_BITS(COUNT_BITS), .RANK_BITS(RANK_BITS)) u_cmp (
      .ctrl        (cmp_ctrl),
      .entry_key   (ram_key),
      .lookup_key  (key_ff),
      .entry_count (ram_count),
      .entry_rank  (ram_rank),
      .best_count  (best_count_ff),
      .best_rank   (best_rank_ff),
      .old_rank    (upd_old_ff),
      .result      (cmp_res)
   );

   always_comb begin
      dec_key_we   = 1'b0;
      dec_value_we = 1'b0;
      dec_count_we = 1'b0;
      dec_count    = (hit_count_ff == COUNT_MAX) ? hit_count_ff : hit_count_ff + COUNT_ONE;
      dec_slot     = slot_ff;
      dec_rank     = 1'b0;
      dec_insert   = 1'b0;
      upd_old_in   = old_rank_ff;
      age_all_in   = 1'b0;
      res_hit_in   = found_ff;
      res_value_in = '0;
      res_evict_in = 1'b0;
      if (func_ff == lfucl_pkg::FUNC_GET) begin
         if (found_ff) begin
            res_value_in = hit_value_ff;
            dec_count_we = 1'b1;
            dec_rank     = 1'b1;
         end else begin
            res_value_in = lfucl_pkg::MISS_VALUE;
         end
      end else if (found_ff) begin
         if (!cap_zero) begin
            dec_value_we = 1'b1;
            dec_count_we = 1'b1;
            dec_rank     = 1'b1;
         end
      end else if (insert_evict) begin
         dec_slot     = best_slot_ff;
         upd_old_in   = best_rank_ff;
         res_evict_in = 1'b1;
         dec_key_we   = 1'b1;
         dec_value_we = 1'b1;
         dec_count_we = 1'b1;
         dec_count    = COUNT_ONE;
         dec_rank     = 1'b1;
      end else if (insert_free) begin
         dec_slot     = free_slot_ff;
         age_all_in   = 1'b1;
         dec_insert   = 1'b1;
         dec_key_we   = 1'b1;
         dec_value_we = 1'b1;
         dec_count_we = 1'b1;
         dec_count    = COUNT_ONE;
         dec_rank     = 1'b1;
      end
      if (state_ff != ST_DECIDE) begin
         dec_key_we   = 1'b0;
         dec_value_we = 1'b0;
         dec_count_we = 1'b0;
      end
   end

   assign rank_we    = (state_ff == ST_RANK) && rd_pend_ff &&
                       (cmp_ctrl.is_slot || cmp_res.rank_age);
   assign rank_wdata = cmp_ctrl.is_slot ? '0 : ram_rank + RANK_BITS'(1);

   always_comb begin
      state_in      = state_ff;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      ctr_in        = ctr_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_addr;
      valid_in      = valid_ff;
      fill_in       = fill_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      old_rank_in   = old_rank_ff;
      hit_count_in  = hit_count_ff;
      hit_value_in  = hit_value_ff;
      have_in       = have_ff;
      best_slot_in  = best_slot_ff;
      best_count_in = best_count_ff;
      best_rank_in  = best_rank_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      upd_slot_in   = upd_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_evicted_in = rsp_evicted_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in       = req_func;
               key_in        = req_lookup_key;
               value_in      = req_put_value;
               ctr_in        = '0;
               found_in      = 1'b0;
               have_in       = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ctr_ff < FILL_MAX) begin
               rd_pend_in = 1'b1;
               ctr_in     = ctr_ff + FILL_BITS'(1);
            end
            if (rd_pend_ff) begin
               if (cmp_res.key_match && !found_ff) begin
                  found_in     = 1'b1;
                  slot_in      = rd_idx_ff;
                  old_rank_in  = ram_rank;
                  hit_count_in = ram_count;
                  hit_value_in = ram_value;
               end
               if (cmp_res.victim_better) begin
                  have_in       = 1'b1;
                  best_slot_in  = rd_idx_ff;
                  best_count_in = ram_count;
                  best_rank_in  = ram_rank;
               end
               if (!cmp_ctrl.valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = rd_idx_ff;
               end
            end
            if (pass_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            upd_slot_in = dec_slot;
            ctr_in      = '0;
            if (dec_insert) begin
               valid_in[dec_slot] = 1'b1;
               fill_in            = fill_ff + FILL_BITS'(1);
            end
            state_in = dec_rank ? ST_RANK : ST_DONE;
         end
         ST_RANK: begin
            if (ctr_ff < FILL_MAX) begin
               rd_pend_in = 1'b1;
               ctr_in     = ctr_ff + FILL_BITS'(1);
            end
            if (pass_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = res_hit_ff;
               rsp_value_in   = res_value_ff;
               rsp_evicted_in = res_evict_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= lfucl_pkg::CAP_RESET;
         ctr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         valid_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         ctr_ff       <= ctr_in;
         rd_pend_ff   <= rd_pend_in;
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      key_ff         <= key_in;
      value_ff       <= value_in;
      rd_idx_ff      <= rd_idx_in;
      found_ff       <= found_in;
      slot_ff        <= slot_in;
      old_rank_ff    <= old_rank_in;
      hit_count_ff   <= hit_count_in;
      hit_value_ff   <= hit_value_in;
      have_ff        <= have_in;
      best_slot_ff   <= best_slot_in;
      best_count_ff  <= best_count_in;
      best_rank_ff   <= best_rank_in;
      free_found_ff  <= free_found_in;
      free_slot_ff   <= free_slot_in;
      upd_slot_ff    <= upd_slot_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_evicted_ff <= rsp_evicted_in;
      if (state_ff == ST_DECIDE) begin
         upd_old_ff   <= upd_old_in;
         age_all_ff   <= age_all_in;
         res_hit_ff   <= res_hit_in;
         res_value_ff <= res_value_in;
         res_evict_ff <= res_evict_in;
      end
   end

   assign req_ready      = state_ff == ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

`ifndef SYNTHESIS
   a_fill_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(fill_ff))
      else $error("fill count differs from number of valid entries");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("fill count above entry count");

   a_free_slot_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && insert_free |-> free_found_ff)
      else $error("insert without a free slot");

   a_victim_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && (func_ff == lfucl_pkg::FUNC_PUT) && !found_ff &&
      !cap_zero && cache_full |-> have_ff)
      else $error("full cache without an eviction candidate");
`endif

endmodule

[tb/sv/tb_lfu_cache_lookup_replace_unit.sv]
module tb_lfu_cache_lookup_replace_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES  = lfucl_pkg::ENTRIES_DEFAULT;
   localparam int CNT_BITS = lfucl_pkg::COUNT_BITS_DEFAULT;
   localparam int POOL     = 24;
   localparam int PHASES   = 8;
   localparam int PER_PHASE = 60;
   localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
      logic        evicted;
   } cache_reply_type;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   class lfu_cache_scoreboard;
      logic [lfucl_pkg::CAP_BITS-1:0] capacity;
      bit                  line_valid[ENTRIES];
      logic [31:0]         line_key[ENTRIES];
      logic [31:0]         line_value[ENTRIES];
      logic [CNT_BITS-1:0] line_count[ENTRIES];
      int                  line_rank[ENTRIES];
      int                  fill;
      int                  errors;
      cache_reply_type     expected_replies[$];

      function new();
         capacity = lfucl_pkg::CAP_RESET;
         fill = 0;
         errors = 0;
         foreach (line_valid[i]) line_valid[i] = 1'b0;
      endfunction

      function void promote(int s, int old_rank);
         foreach (line_valid[i])
            if (line_valid[i] && i != s && line_rank[i] < old_rank) line_rank[i]++;
         line_rank[s] = 0;
      endfunction

      function void bump(int s);
         if (line_count[s] != CNT_MAX) line_count[s]++;
      endfunction

      function void note_access(logic func, logic [31:0] key, logic [31:0] value);
         int              cap;
         int              slot;
         int              i;
         bit              found;
         bit              have;
         bit              placed;
         cache_reply_type r;
         cap = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
         slot = 0;
         found = 1'b0;
         have = 1'b0;
         placed = 1'b0;
         r = '0;
         for (i = 0; i < ENTRIES; i++)
            if (!found && line_valid[i] && line_key[i] == key) begin
               slot = i;
               found = 1'b1;
            end
         if (func == lfucl_pkg::FUNC_GET) begin
            if (found) begin
               r.hit = 1'b1;
               r.read_value = line_value[slot];
               bump(slot);
               promote(slot, line_rank[slot]);
            end else begin
               r.read_value = lfucl_pkg::MISS_VALUE;
            end
         end else if (found) begin
            r.hit = 1'b1;
            if (cap != 0) begin
               line_value[slot] = value;
               bump(slot);
               promote(slot, line_rank[slot]);
            end
         end else if (cap != 0) begin
            if (fill >= cap) begin
               for (i = 0; i < ENTRIES; i++) begin
                  if (line_valid[i] && (!have || line_count[i] < line_count[slot] ||
                      (line_count[i] == line_count[slot] && line_rank[i] > line_rank[slot])))
                  begin
                     slot = i;
                     have = 1'b1;
                  end
               end
               if (have) begin
                  r.evicted = 1'b1;
                  promote(slot, line_rank[slot]);
               end
            end
            if (!r.evicted) begin
               for (i = 0; i < ENTRIES; i++)
                  if (!placed && !line_valid[i]) begin
                     slot = i;
                     placed = 1'b1;
                  end
               promote(slot, ENTRIES);
               line_valid[slot] = 1'b1;
               fill++;
            end
            line_key[slot] = key;
            line_value[slot] = value;
            line_count[slot] = CNT_BITS'(1);
         end
         expected_replies.push_back(r);
      endfunction

      function void check_reply(logic hit, logic [31:0] read_value, logic evicted);
         cache_reply_type want;
         if (expected_replies.size() == 0) begin
            $display("%0t: reply with none pending: hit %0b value %h evicted %0b",
                     $time, hit, read_value, evicted);
            errors++;
            return;
         end
         want = expected_replies.pop_front();
         if (hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
            errors++;
         end
         if (read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                     read_value);
            errors++;
         end
         if (evicted !== want.evicted) begin
            $display("%0t: evicted expected %0b actual %0b", $time, want.evicted, evicted);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset          = 1'b1;
   logic        csr_wr_en      = 1'b0;
   logic [4:0]  csr_wr_data    = '0;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic        req_func       = lfucl_pkg::FUNC_GET;
   logic signed [31:0] req_lookup_key = '0;
   logic signed [31:0] req_put_value  = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic        rsp_hit;
   logic signed [31:0] rsp_read_value;
   logic        rsp_evicted;

   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   logic [31:0] key_pool[POOL];
   logic [4:0]  phase_caps[PHASES] = '{5'd31, 5'd3, 5'd16, 5'd1, 5'd0, 5'd7, 5'd20, 5'd2};

   lfu_cache_scoreboard shadow_cache = new();

   lfu_cache_lookup_replace_unit #(
      .ENTRIES   (ENTRIES),
      .COUNT_BITS(CNT_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_lookup_key(req_lookup_key),
      .req_put_value (req_put_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hit       (rsp_hit),
      .rsp_read_value(rsp_read_value),
      .rsp_evicted   (rsp_evicted)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   initial forever begin
      @(posedge clock);
      if (!reset && rsp_valid && rsp_ready)
         shadow_cache.check_reply(rsp_hit, rsp_read_value, rsp_evicted);
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 85;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            recv_stall_pct = 85;
         end
         default: begin
            send_idle_pct = 9;
            recv_stall_pct = 9;
         end
      endcase
   endtask

   task automatic send_word(logic func, logic [31:0] key, logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid      <= 1'b0;
         req_func       <= 1'($urandom);
         req_lookup_key <= $urandom;
         req_put_value  <= $urandom;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_lookup_key <= key;
      req_put_value  <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shadow_cache.note_access(func, key, value);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (shadow_cache.expected_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [4:0] cap);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_cache.capacity = cap;
   endtask

   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 35) return key_pool[r % 2];
      if (r < 90) return key_pool[$urandom_range(POOL - 1)];
      return $urandom;
   endfunction

   initial begin
      int phase;
      int n;
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      key_pool[4] = 32'h0000_0000;
      key_pool[5] = 32'hFFFF_FFFF;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_word(lfucl_pkg::FUNC_GET, 32'h0000_0000, 32'h5555_5555);
      send_word(lfucl_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(lfucl_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(lfucl_pkg::FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
      send_word(lfucl_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(lfucl_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_word(lfucl_pkg::FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      send_word(lfucl_pkg::FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
      send_word(lfucl_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
      send_word(lfucl_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(lfucl_pkg::FUNC_GET, 32'h0000_0001, 32'h0000_0000);

      write_capacity(5'd0);
      send_word(lfucl_pkg::FUNC_PUT, 32'h0000_0005, 32'h0000_0005);
      send_word(lfucl_pkg::FUNC_PUT, 32'h0000_0000, 32'hAAAA_AAAA);
      send_word(lfucl_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
      send_word(lfucl_pkg::FUNC_GET, 32'h0000_0005, 32'h0000_0000);

      write_capacity(5'd2);
      send_word(lfucl_pkg::FUNC_PUT, 32'h0000_0006, 32'h0000_0006);
      send_word(lfucl_pkg::FUNC_PUT, 32'h0000_0007, 32'h0000_0007);
      send_word(lfucl_pkg::FUNC_GET, 32'h0000_0006, 32'h0000_0000);
      send_word(lfucl_pkg::FUNC_GET, 32'h0000_0007, 32'h0000_0000);

      for (phase = 0; phase < PHASES; phase++) begin
         write_capacity(phase_caps[phase]);
         set_idling(idle_mode_type'(phase % 4));
         for (n = 0; n < PER_PHASE; n++)
            send_word(1'($urandom), pick_key(), $urandom);
      end

      drain();
      repeat (2 * ENTRIES + 8) @(posedge clock);
      if (shadow_cache.errors == 0 && shadow_cache.expected_replies.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
